/* rtl/core/lrd_pkg.sv */
package lrd_pkg;

  localparam int unsigned ResultDepthDefault = 4;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] SatMax  = 32'hFFFF_FFFF;

  localparam logic [23:0] MaxLenReset = 24'h10_0000;

  localparam logic [3:0] HdrLastIdx = 4'd15;

  // Register index as decoded from paddr[2]
  localparam logic RegMagic  = 1'b0;
  localparam logic RegMaxLen = 1'b1;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTorn    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ResPayload   = 2'd0,
    ResRecordEnd = 2'd1,
    ResSummary   = 2'd2
  } result_kind_e;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   payload_byte;
    logic [31:0]  record_seq;
    logic [23:0]  record_length;
    logic         record_ok;
    logic [31:0]  records_replayed;
    logic [31:0]  valid_bytes;
    logic [31:0]  torn_bytes;
    logic         tail_torn;
    logic         last;
  } result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* rtl/core/log_record_deframer_crc32.sv */
// Log record deframer with CRC-32 check. Takes one stream byte (kind 0) or an
// end-of-stream marker (kind 1) per transfer. Each record is a 16-byte
// little-endian header (magic, sequence, length, CRC-32) and a payload; payload
// bytes come out as they arrive, and the last one is followed by a record-end
// result carrying sequence, length and the CRC verdict. A bad magic, a length
// above max_payload_length, a CRC mismatch or a record cut short by end of
// stream stops parsing; later bytes are counted as torn. End of stream yields
// one summary and re-arms the parser (registers are kept). Input is accepted
// at one byte per cycle while at least two of the ResultDepth result queue
// slots are free; results are written into that queue when the input transfer
// is taken and leave it in order. A closing payload byte gives two results.
// Registers: record_magic at 0x0, max_payload_length at 0x4 (APB, no wait).
module log_record_deframer_crc32 #(
  parameter int unsigned ResultDepth = lrd_pkg::ResultDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] record_seq_o,
  output logic [23:0] record_length_o,
  output logic        record_ok_o,
  output logic [31:0] records_replayed_o,
  output logic [31:0] valid_bytes_o,
  output logic [31:0] torn_bytes_o,
  output logic        tail_torn_o,
  output logic        last_o
);
  import lrd_pkg::*;

  localparam int unsigned PtrW = (ResultDepth > 2) ? $clog2(ResultDepth) : 1;
  localparam int unsigned CntW = $clog2(ResultDepth + 1);

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [1:0] lane,
                                           logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = v;
    return r;
  endfunction

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(ResultDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // Configuration registers
  logic [31:0] magic_cfg_q;
  logic [23:0] max_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegMaxLen) ? {8'd0, max_len_q} : magic_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg_q <= '0;
      max_len_q   <= MaxLenReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegMagic) begin
        magic_cfg_q <= pwdata;
      end else begin
        max_len_q <= pwdata[23:0];
      end
    end
  end

  // Parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] hdr_magic_q, hdr_magic_d;
  logic [31:0] hdr_seq_q, hdr_seq_d;
  logic [31:0] hdr_len_q, hdr_len_d;
  logic [31:0] hdr_crc_q, hdr_crc_d;
  logic [23:0] pay_rem_q, pay_rem_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] good_cnt_q, good_cnt_d;
  logic [31:0] good_off_q, good_off_d;
  logic [31:0] total_q, total_d;

  // Result queue
  result_t         res_mem_q [ResultDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  result_t         res0, res1;
  logic [1:0]      n_res;
  logic            acc, pop;

  assign in_ready_o  = (cnt_q <= CntW'(ResultDepth - 2));
  assign acc         = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;

  // Decode of the current byte against the current state
  logic        hdr_last, hdr_bad, zero_len, pay_end, crc_ok_pay, crc_ok_zero;
  logic [31:0] crc_upd, total_inc, torn;
  logic [31:0] good_cnt_inc;

  assign crc_upd      = crc32_byte(crc_q, data_byte_i);
  assign hdr_last     = (hdr_idx_q == HdrLastIdx);
  assign hdr_bad      = (hdr_magic_q != magic_cfg_q) || (hdr_len_q > {8'd0, max_len_q});
  assign zero_len     = (hdr_len_q == '0);
  assign crc_ok_zero  = (put_lane(hdr_crc_q, hdr_idx_q[1:0], data_byte_i) == ~CrcInit);
  assign pay_end      = (pay_rem_q == 24'd1);
  assign crc_ok_pay   = ((crc_upd ^ CrcInit) == hdr_crc_q);
  assign total_inc    = (total_q == SatMax) ? total_q : total_q + 32'd1;
  assign good_cnt_inc = (good_cnt_q == SatMax) ? good_cnt_q : good_cnt_q + 32'd1;
  assign torn         = total_q - good_off_q;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      if (kind_i) begin
        phase_d = PhHeader;
      end else begin
        case (phase_q)
          PhHeader: begin
            if (hdr_last) begin
              if (hdr_bad) begin
                phase_d = PhTorn;
              end else if (zero_len) begin
                phase_d = crc_ok_zero ? PhHeader : PhTorn;
              end else begin
                phase_d = PhPayload;
              end
            end
          end
          PhPayload: begin
            if (pay_end) begin
              phase_d = crc_ok_pay ? PhHeader : PhTorn;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath and results
  always_comb begin
    hdr_idx_d   = hdr_idx_q;
    hdr_magic_d = hdr_magic_q;
    hdr_seq_d   = hdr_seq_q;
    hdr_len_d   = hdr_len_q;
    hdr_crc_d   = hdr_crc_q;
    pay_rem_d   = pay_rem_q;
    crc_d       = crc_q;
    good_cnt_d  = good_cnt_q;
    good_off_d  = good_off_q;
    total_d     = total_q;
    res0        = '0;
    res1        = '0;
    n_res       = 2'd0;
    if (acc) begin
      if (kind_i) begin
        res0.kind             = ResSummary;
        res0.records_replayed = good_cnt_q;
        res0.valid_bytes      = good_off_q;
        res0.torn_bytes       = torn;
        res0.tail_torn        = (torn != '0);
        res0.last             = 1'b1;
        n_res                 = 2'd1;
        hdr_idx_d   = '0;
        hdr_magic_d = '0;
        hdr_seq_d   = '0;
        hdr_len_d   = '0;
        hdr_crc_d   = '0;
        pay_rem_d   = '0;
        crc_d       = CrcInit;
        good_cnt_d  = '0;
        good_off_d  = '0;
        total_d     = '0;
      end else begin
        total_d = total_inc;
        case (phase_q)
          PhHeader: begin
            case (hdr_idx_q[3:2])
              2'd0:    hdr_magic_d = put_lane(hdr_magic_q, hdr_idx_q[1:0], data_byte_i);
              2'd1:    hdr_seq_d   = put_lane(hdr_seq_q, hdr_idx_q[1:0], data_byte_i);
              2'd2:    hdr_len_d   = put_lane(hdr_len_q, hdr_idx_q[1:0], data_byte_i);
              default: hdr_crc_d   = put_lane(hdr_crc_q, hdr_idx_q[1:0], data_byte_i);
            endcase
            if (!hdr_last) begin
              hdr_idx_d = hdr_idx_q + 4'd1;
            end else begin
              hdr_idx_d = '0;
              crc_d     = CrcInit;
              if (!hdr_bad && zero_len) begin
                res0.kind          = ResRecordEnd;
                res0.record_seq    = hdr_seq_q;
                res0.record_length = hdr_len_q[23:0];
                res0.record_ok     = crc_ok_zero;
                res0.last          = 1'b1;
                n_res              = 2'd1;
                if (crc_ok_zero) begin
                  good_cnt_d = good_cnt_inc;
                  good_off_d = total_inc;
                end
              end else if (!hdr_bad) begin
                pay_rem_d = hdr_len_q[23:0];
              end
            end
          end
          PhPayload: begin
            crc_d              = crc_upd;
            pay_rem_d          = pay_rem_q - 24'd1;
            res0.kind          = ResPayload;
            res0.payload_byte  = data_byte_i;
            res0.record_seq    = hdr_seq_q;
            res0.record_length = hdr_len_q[23:0];
            res0.last          = !pay_end;
            n_res              = 2'd1;
            if (pay_end) begin
              res1.kind          = ResRecordEnd;
              res1.record_seq    = hdr_seq_q;
              res1.record_length = hdr_len_q[23:0];
              res1.record_ok     = crc_ok_pay;
              res1.last          = 1'b1;
              n_res              = 2'd2;
              if (crc_ok_pay) begin
                good_cnt_d = good_cnt_inc;
                good_off_d = total_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      hdr_idx_q   <= '0;
      hdr_magic_q <= '0;
      hdr_seq_q   <= '0;
      hdr_len_q   <= '0;
      hdr_crc_q   <= '0;
      pay_rem_q   <= '0;
      crc_q       <= CrcInit;
      good_cnt_q  <= '0;
      good_off_q  <= '0;
      total_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      hdr_magic_q <= hdr_magic_d;
      hdr_seq_q   <= hdr_seq_d;
      hdr_len_q   <= hdr_len_d;
      hdr_crc_q   <= hdr_crc_d;
      pay_rem_q   <= pay_rem_d;
      crc_q       <= crc_d;
      good_cnt_q  <= good_cnt_d;
      good_off_q  <= good_off_d;
      total_q     <= total_d;
    end
  end

  // Result queue: up to two writes per accepted byte, one read per cycle while a result waits and out_ready_i is high
  logic [PtrW-1:0] wptr1;
  logic            push1, push2;

  assign wptr1 = ptr_inc(wptr_q);
  assign push1 = acc & (n_res != 2'd0);
  assign push2 = acc & (n_res == 2'd2);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResultDepth; i++) begin
      if (push1 && (wptr_q == PtrW'(i))) begin
        res_mem_q[i] <= res0;
      end else if (push2 && (wptr1 == PtrW'(i))) begin
        res_mem_q[i] <= res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push2) begin
        wptr_q <= ptr_inc(wptr1);
      end else if (push1) begin
        wptr_q <= wptr1;
      end
      if (pop) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      cnt_q <= cnt_q + CntW'(push1) + CntW'(push2) - CntW'(pop);
    end
  end

  result_t head;
  assign head = res_mem_q[rptr_q];

  assign result_kind_o      = head.kind;
  assign payload_byte_o     = head.payload_byte;
  assign record_seq_o       = head.record_seq;
  assign record_length_o    = head.record_length;
  assign record_ok_o        = head.record_ok;
  assign records_replayed_o = head.records_replayed;
  assign valid_bytes_o      = head.valid_bytes;
  assign torn_bytes_o       = head.torn_bytes;
  assign tail_torn_o        = head.tail_torn;
  assign last_o             = head.last;

endmodule

/* rtl/core/lrd_checker.sv */
module lrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        kind_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [31:0] record_seq_o,
  input logic [23:0] record_length_o,
  input logic        record_ok_o,
  input logic [31:0] records_replayed_o,
  input logic [31:0] valid_bytes_o,
  input logic [31:0] torn_bytes_o,
  input logic        tail_torn_o,
  input logic        last_o
);
  import lrd_pkg::*;

  // stalled transfer holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(payload_byte_o) && $stable(last_o) && $stable(torn_bytes_o))
    else $error("output transfer changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == ResPayload) || (result_kind_o == ResRecordEnd)
      || (result_kind_o == ResSummary))
    else $error("undefined result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != ResPayload) |-> last_o)
    else $error("record end or summary without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ResSummary) |-> tail_torn_o == (torn_bytes_o != '0))
    else $error("tail_torn disagrees with torn_bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ResPayload) && !last_o && out_ready_i
      |=> out_valid_o && (result_kind_o == ResRecordEnd)
        && (record_seq_o == $past(record_seq_o)))
    else $error("final payload byte not followed by its record end");

endmodule

bind log_record_deframer_crc32 lrd_checker u_lrd_checker (.*);

/* dv/tb_log_record_deframer_crc32.sv */
`timescale 1ns / 100ps

module tb_log_record_deframer_crc32;
  import lrd_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } stream_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] record_seq_o;
  logic [23:0] record_length_o;
  logic        record_ok_o;
  logic [31:0] records_replayed_o;
  logic [31:0] valid_bytes_o;
  logic [31:0] torn_bytes_o;
  logic        tail_torn_o;
  logic        last_o;

  log_record_deframer_crc32 dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .payload_byte_o     (payload_byte_o),
    .record_seq_o       (record_seq_o),
    .record_length_o    (record_length_o),
    .record_ok_o        (record_ok_o),
    .records_replayed_o (records_replayed_o),
    .valid_bytes_o      (valid_bytes_o),
    .torn_bytes_o       (torn_bytes_o),
    .tail_torn_o        (tail_torn_o),
    .last_o             (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Register shadow
  logic [31:0] cfg_magic = '0;
  logic [23:0] cfg_max_len = MaxLenReset;

  // Parser shadow
  phase_e      rx_phase = PhHeader;
  logic [3:0]  hdr_idx = '0;
  logic [31:0] hdr_magic = '0;
  logic [31:0] hdr_seq = '0;
  logic [31:0] hdr_len = '0;
  logic [31:0] hdr_crc = '0;
  logic [23:0] bytes_left = '0;
  logic [31:0] crc_acc = '1;
  logic [31:0] good_records = '0;
  logic [31:0] good_end = '0;
  logic [31:0] byte_total = '0;

  stream_item_t log_stream[$];
  result_t      awaited_results[$];
  stream_item_t in_flight;
  int           stream_len = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           in_gap = 0;
  int           out_stall = 0;
  int           pace = 0;
  int           pace_left = 0;

  function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    repeat (8) x = (x >> 1) ^ (CrcPoly & {32{x[0]}});
    return x;
  endfunction

  function automatic void rearm_parser();
    rx_phase     = PhHeader;
    hdr_idx      = '0;
    hdr_magic    = '0;
    hdr_seq      = '0;
    hdr_len      = '0;
    hdr_crc      = '0;
    bytes_left   = '0;
    crc_acc      = '1;
    good_records = '0;
    good_end     = '0;
    byte_total   = '0;
  endfunction

  function automatic void close_record();
    result_t r;
    r = '0;
    r.kind          = ResRecordEnd;
    r.record_seq    = hdr_seq;
    r.record_length = hdr_len[23:0];
    r.record_ok     = (~crc_acc == hdr_crc);
    r.last          = 1'b1;
    awaited_results.insert(awaited_results.size(), r);
    if (r.record_ok) begin
      if (good_records != '1) good_records++;
      good_end = byte_total;
      rx_phase = PhHeader;
    end else begin
      rx_phase = PhTorn;
    end
  endfunction

  function automatic void deframe_item(stream_item_t it);
    result_t     r;
    logic [31:0] torn;
    r = '0;
    if (it.kind) begin
      torn               = byte_total - good_end;
      r.kind             = ResSummary;
      r.records_replayed = good_records;
      r.valid_bytes      = good_end;
      r.torn_bytes       = torn;
      r.tail_torn        = (torn != 0);
      r.last             = 1'b1;
      awaited_results.insert(awaited_results.size(), r);
      rearm_parser();
      return;
    end
    if (byte_total != '1) byte_total++;
    case (rx_phase)
      PhHeader: begin
        case (hdr_idx[3:2])
          2'd0: hdr_magic[8*hdr_idx[1:0] +: 8] = it.data;
          2'd1: hdr_seq[8*hdr_idx[1:0] +: 8] = it.data;
          2'd2: hdr_len[8*hdr_idx[1:0] +: 8] = it.data;
          default: hdr_crc[8*hdr_idx[1:0] +: 8] = it.data;
        endcase
        if (hdr_idx != HdrLastIdx) begin
          hdr_idx++;
        end else begin
          hdr_idx = '0;
          crc_acc = '1;
          if (hdr_magic != cfg_magic || hdr_len > {8'd0, cfg_max_len}) begin
            rx_phase = PhTorn;
          end else if (hdr_len == 0) begin
            close_record();
          end else begin
            bytes_left = hdr_len[23:0];
            rx_phase   = PhPayload;
          end
        end
      end
      PhPayload: begin
        crc_acc = crc32_update(crc_acc, it.data);
        bytes_left--;
        r.kind          = ResPayload;
        r.payload_byte  = it.data;
        r.record_seq    = hdr_seq;
        r.record_length = hdr_len[23:0];
        r.last          = (bytes_left != 0);
        awaited_results.insert(awaited_results.size(), r);
        if (bytes_left == 0) close_record();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, kind %h", $time, result_kind_o);
      return;
    end
    want = awaited_results.pop_front();
    check_field("result_kind", 32'(want.kind), 32'(result_kind_o));
    check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
    check_field("record_seq", want.record_seq, record_seq_o);
    check_field("record_length", 32'(want.record_length), 32'(record_length_o));
    check_field("record_ok", 32'(want.record_ok), 32'(record_ok_o));
    check_field("records_replayed", want.records_replayed, records_replayed_o);
    check_field("valid_bytes", want.valid_bytes, valid_bytes_o);
    check_field("torn_bytes", want.torn_bytes, torn_bytes_o);
    check_field("tail_torn", 32'(want.tail_torn), 32'(tail_torn_o));
    check_field("last", 32'(want.last), 32'(last_o));
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 0;
      1: return (r < 75) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      default: return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(8, 40);
    endcase
  endfunction

  // Burst / stall intensity, shared by both sides
  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      pace      <= $urandom_range(0, 2);
      pace_left <= $urandom_range(40, 400);
    end else begin
      pace_left <= pace_left - 1;
    end
  end

  always @(posedge clk_i) begin : stream_feed
    if (in_valid_i && in_ready_o) deframe_item(in_flight);
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (log_stream.size() != 0) begin
        in_flight = log_stream.pop_front();
        kind_i      <= in_flight.kind;
        data_byte_i <= in_flight.data;
        in_valid_i  <= 1'b1;
        in_gap = pick_gap(pace);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_sink
    if (out_valid_o && out_ready_i) check_result();
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_stall = pick_gap(pace);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_log_record_deframer_crc32: FAIL");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    stream_item_t it;
    it.kind = 1'b0;
    it.data = b;
    log_stream.insert(log_stream.size(), it);
    stream_len++;
  endfunction

  function automatic void push_eos();
    stream_item_t it;
    it.kind = 1'b1;
    it.data = 8'($urandom);
    log_stream.insert(log_stream.size(), it);
    stream_len++;
  endfunction

  function automatic void push_noise(int n);
    repeat (n) push_byte(8'($urandom));
  endfunction

  function automatic void maybe_rearm();
    if ($urandom_range(0, 9) < 6) push_eos();
  endfunction

  // Header plus nbytes of payload; hdr_keep < 16 cuts the header short
  function automatic void push_record(logic [31:0] magic, logic [31:0] seq, logic [31:0] len32,
                                      int nbytes, bit crc_good, int hdr_keep);
    logic [7:0]   body[$];
    logic [7:0]   b;
    logic [31:0]  crc;
    logic [127:0] hdr;
    crc = '1;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      body.insert(body.size(), b);
      crc = crc32_update(crc, b);
    end
    crc = ~crc;
    if (!crc_good) crc ^= 32'h1 << $urandom_range(0, 31);
    hdr = {crc, len32, seq, magic};
    for (int i = 0; i < hdr_keep; i++) push_byte(hdr[8*i +: 8]);
    foreach (body[i]) push_byte(body[i]);
  endfunction

  function automatic int pick_len();
    int len;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 48);
    if (len > int'(cfg_max_len)) len = int'(cfg_max_len);
    return len;
  endfunction

  function automatic void gen_stream(int budget);
    int          start;
    int          r;
    int          len;
    int          lim;
    logic [31:0] len32;
    start = stream_len;
    while (stream_len - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = pick_len();
        push_record(cfg_magic, $urandom, len, len, 1'b1, 16);
      end else if (r < 68) begin
        len = pick_len();
        push_record(cfg_magic, $urandom, len, len, 1'b0, 16);
        maybe_rearm();
      end else if (r < 74) begin
        push_record(cfg_magic ^ (32'h1 << $urandom_range(0, 31)), $urandom, pick_len(), 0,
                    1'b1, 16);
        push_noise($urandom_range(0, 5));
        maybe_rearm();
      end else if (r < 80) begin
        if (cfg_max_len == 24'hFF_FFFF) begin
          len32 = {8'($urandom_range(1, 255)), 24'($urandom)};
        end else if ($urandom_range(0, 4) == 0) begin
          len32 = 32'hFFFF_FFFF;
        end else begin
          len32 = {8'd0, cfg_max_len} + 32'($urandom_range(1, 3));
        end
        push_record(cfg_magic, $urandom, len32, 0, 1'b1, 16);
        push_noise($urandom_range(0, 5));
        maybe_rearm();
      end else if (r < 88) begin
        // record cut short by end of stream
        if (cfg_max_len == 0 || $urandom_range(0, 3) == 0) begin
          push_record(cfg_magic, $urandom, pick_len(), 0, 1'b1, $urandom_range(1, 15));
        end else begin
          lim = (cfg_max_len < 48) ? int'(cfg_max_len) : 48;
          len = ($urandom_range(0, 9) == 0) ? int'(cfg_max_len) : $urandom_range(1, lim);
          lim = (len - 1 < 30) ? len - 1 : 30;
          push_record(cfg_magic, $urandom, len, $urandom_range(0, lim), 1'b1, 16);
        end
        push_eos();
      end else if (r < 94) begin
        push_eos();
      end else begin
        push_noise($urandom_range(1, 12));
      end
    end
  endfunction

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMagic) cfg_magic = value;
    else cfg_max_len = value[23:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", (idx == RegMagic) ? cfg_magic : {8'd0, cfg_max_len}, readback);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (log_stream.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : sequencer
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: empty summary, zero-length record, CRC failure, torn tail
    push_eos();
    push_record(32'h0, 32'hFFFF_FFFF, 32'd0, 0, 1'b1, 16);
    push_record(32'h0, 32'h0, 32'd1, 1, 1'b0, 16);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_eos();
    gen_stream(250);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          cfg_write(RegMagic, 32'hFFFF_FFFF);
          cfg_write(RegMaxLen, {8'hA5, 24'd0});
        end
        1: begin
          cfg_write(RegMagic, $urandom);
          cfg_write(RegMaxLen, {8'($urandom), 24'hFF_FFFF});
        end
        2: begin
          cfg_write(RegMagic, 32'h0);
          cfg_write(RegMaxLen, {8'hFF, 24'd1});
        end
        3: begin
          cfg_write(RegMagic, $urandom);
          cfg_write(RegMaxLen, {8'($urandom), 24'($urandom_range(2, 40))});
        end
        default: begin
          cfg_write(RegMagic, $urandom);
          cfg_write(RegMaxLen, {8'h00, MaxLenReset});
        end
      endcase
      push_eos();
      gen_stream(250);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end
    if (mismatches == 0) begin
      $display("tb_log_record_deframer_crc32: PASS");
    end else begin
      $display("tb_log_record_deframer_crc32: FAIL");
    end
    $finish;
  end

endmodule
